// ----- hdl/gllf_pkg.sv -----
// Shared types and constants for the listing line field locator.
// No dependencies.
package gllf_pkg;

    localparam int CHAR_W  = 8;
    localparam int TOTAL_W = 13;
    localparam int START_W = 12;
    localparam int LEN_W   = 13;
    localparam int KIND_W  = 3;

    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_TITLE    = 3'd0;
    localparam kind_t KIND_YEAR     = 3'd1;
    localparam kind_t KIND_TYPE     = 3'd2;
    localparam kind_t KIND_SUBTITLE = 3'd3;
    localparam kind_t KIND_GENRE    = 3'd4;
    localparam kind_t KIND_NONE     = 3'd5;

    localparam logic [CHAR_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;

    typedef struct packed {
        kind_t kind;
        logic  line_done;
        logic  truncated;
    } rec_meta_t;

endpackage

// ----- hdl/gllf_front.sv -----
// Front end: takes one character per request, keeps the parse state and
// classifies delimiters into field records. Depends on gllf_pkg.
module gllf_front import gllf_pkg::*; #(
    parameter int MAX_LINE = 4096,
    parameter int CW       = 13
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [CHAR_W-1:0]  char_code,
    input  logic [TOTAL_W-1:0] line_length,
    input  logic               line_last,
    input  logic               q_full,
    output logic               push,
    output rec_meta_t          rec_meta,
    output logic [CW-1:0]      rec_start,
    output logic [CW-1:0]      rec_want,
    output logic [TOTAL_W-1:0] rec_total
);

    localparam logic [CW-1:0] MAX_C = CW'(MAX_LINE);

    logic [CW-1:0] pos_reg, pos_next;
    logic [CW-1:0] start_reg, start_next;
    logic [CW-1:0] run_reg, run_next;
    logic quote_reg, quote_next;
    logic brace_reg, brace_next;
    logic year_open_reg, year_open_next;
    logic type_open_reg, type_open_next;
    logic is_film_reg, is_film_next;
    logic title_found_reg, title_found_next;
    logic year_found_reg, year_found_next;
    logic armed_reg, armed_next;
    logic skip_reg, skip_next;
    logic ovf_reg, ovf_next;

    logic          accept;
    logic          found;
    kind_t         kind;
    logic [CW-1:0] run_inc;
    logic [CW-1:0] idx1;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign run_inc  = (run_reg < MAX_C) ? run_reg + CW'(1) : run_reg;
    assign idx1     = pos_reg + CW'(1);

    always_comb begin
        pos_next         = pos_reg;
        start_next       = start_reg;
        run_next         = run_reg;
        quote_next       = quote_reg;
        brace_next       = brace_reg;
        year_open_next   = year_open_reg;
        type_open_next   = type_open_reg;
        is_film_next     = is_film_reg;
        title_found_next = title_found_reg;
        year_found_next  = year_found_reg;
        armed_next       = armed_reg;
        skip_next        = skip_reg;
        ovf_next         = ovf_reg;
        found            = 1'b0;
        kind             = KIND_NONE;
        if (pos_reg >= MAX_C) begin
            ovf_next = 1'b1;
        end else begin
            pos_next = idx1;
            if (!skip_reg) begin
                run_next = run_inc;
                unique case (char_code)
                    CH_QUOTE: begin
                        is_film_next = 1'b0;
                        if (!quote_reg) begin
                            quote_next = 1'b1;
                            start_next = idx1;
                            run_next   = '0;
                        end else begin
                            found      = 1'b1;
                            kind       = KIND_TITLE;
                            run_next   = '0;
                            quote_next = 1'b0;
                        end
                    end
                    CH_LPAREN: begin
                        if (!quote_reg && !brace_reg) begin
                            if (is_film_reg && !title_found_reg) begin
                                found            = 1'b1;
                                kind             = KIND_TITLE;
                                title_found_next = 1'b1;
                            end
                            if (!year_open_reg && !year_found_reg) begin
                                year_open_next = 1'b1;
                                start_next     = idx1;
                                run_next       = '0;
                            end
                            if (is_film_reg && year_found_reg && !type_open_reg) begin
                                type_open_next = 1'b1;
                                start_next     = idx1;
                                run_next       = '0;
                            end
                        end
                    end
                    CH_RPAREN: begin
                        if (!quote_reg && !brace_reg) begin
                            if (year_open_reg && !type_open_reg && !year_found_reg) begin
                                found           = 1'b1;
                                kind            = KIND_YEAR;
                                run_next        = '0;
                                year_open_next  = 1'b0;
                                year_found_next = 1'b1;
                            end else if (type_open_reg && year_found_reg) begin
                                found          = 1'b1;
                                kind           = KIND_TYPE;
                                run_next       = '0;
                                type_open_next = 1'b0;
                            end
                        end
                    end
                    CH_LBRACE: begin
                        if (!brace_reg) begin
                            brace_next = 1'b1;
                            start_next = idx1;
                            run_next   = '0;
                        end
                    end
                    CH_RBRACE: begin
                        if (brace_reg) begin
                            found      = 1'b1;
                            kind       = KIND_SUBTITLE;
                            run_next   = '0;
                            brace_next = 1'b0;
                        end
                    end
                    CH_TAB: begin
                        armed_next = 1'b1;
                        start_next = idx1;
                    end
                    default: begin
                        if (armed_reg) begin
                            found      = 1'b1;
                            kind       = KIND_GENRE;
                            run_next   = '0;
                            armed_next = 1'b0;
                            skip_next  = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // run_inc is at least one whenever a field is reported
    assign push               = accept && (found || line_last);
    assign rec_meta.kind      = kind;
    assign rec_meta.line_done = line_last;
    assign rec_meta.truncated = ovf_next;
    assign rec_start          = start_reg;
    assign rec_want           = run_inc - CW'(1);
    assign rec_total          = line_length;

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && line_last)) begin
            pos_reg         <= '0;
            start_reg       <= '0;
            run_reg         <= '0;
            quote_reg       <= 1'b0;
            brace_reg       <= 1'b0;
            year_open_reg   <= 1'b0;
            type_open_reg   <= 1'b0;
            is_film_reg     <= 1'b1;
            title_found_reg <= 1'b0;
            year_found_reg  <= 1'b0;
            armed_reg       <= 1'b0;
            skip_reg        <= 1'b0;
            ovf_reg         <= 1'b0;
        end else if (accept) begin
            pos_reg         <= pos_next;
            start_reg       <= start_next;
            run_reg         <= run_next;
            quote_reg       <= quote_next;
            brace_reg       <= brace_next;
            year_open_reg   <= year_open_next;
            type_open_reg   <= type_open_next;
            is_film_reg     <= is_film_next;
            title_found_reg <= title_found_next;
            year_found_reg  <= year_found_next;
            armed_reg       <= armed_next;
            skip_reg        <= skip_next;
            ovf_reg         <= ovf_next;
        end
    end

endmodule

// ----- hdl/gllf_queue.sv -----
// Two-entry record queue between front and back end.
// Imports gllf_pkg but uses none of its items.
module gllf_queue import gllf_pkg::*; #(
    parameter int W = 48
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] wr_data,
    output logic         full,
    input  logic         pop,
    output logic         head_valid,
    output logic [W-1:0] rd_data
);

    logic [W-1:0] mem_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign rd_data    = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ----- hdl/gllf_back.sv -----
// Back end: works out field lengths and holds the result register.
// Depends on gllf_pkg.
module gllf_back import gllf_pkg::*; #(
    parameter int CW = 13
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               head_valid,
    output logic               pop,
    input  rec_meta_t          rec_meta,
    input  logic [CW-1:0]      rec_start,
    input  logic [CW-1:0]      rec_want,
    input  logic [TOTAL_W-1:0] rec_total,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata,
    output logic [3:0]         m_tuser,
    output logic               m_tlast
);

    localparam int LW = (CW > TOTAL_W) ? CW : TOTAL_W;

    logic [LW-1:0] tot_x, st_x, want_x, room, len;
    logic [START_W-1:0] start_o;
    logic [LEN_W-1:0]   len_o;

    logic               m_valid_reg;
    logic [START_W-1:0] start_reg;
    logic [LEN_W-1:0]   len_reg;
    rec_meta_t          meta_reg;

    assign tot_x  = LW'(rec_total);
    assign st_x   = LW'(rec_start);
    assign want_x = LW'(rec_want);
    assign room   = (tot_x >= st_x) ? tot_x - st_x : '0;

    always_comb begin
        if (rec_meta.kind == KIND_GENRE) begin
            len = room;
        end else begin
            len = (want_x < room) ? want_x : room;
        end
        if (rec_meta.kind == KIND_NONE) begin
            start_o = '0;
            len_o   = '0;
        end else begin
            start_o = START_W'(rec_start);
            len_o   = LEN_W'(len);
        end
    end

    assign pop = head_valid && (!m_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_tready) begin
            m_valid_reg <= head_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            start_reg <= start_o;
            len_reg   <= len_o;
            meta_reg  <= rec_meta;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, len_reg, start_reg};
    assign m_tuser  = {meta_reg.truncated, meta_reg.kind};
    assign m_tlast  = meta_reg.line_done;

endmodule

// ----- hdl/genre_line_field_locator.sv -----
// Listing line field locator: one character per cycle in while the queue has room, field records out.
// An accepted character's record passes through the queue and then the result register to m_tvalid.
// Throughput: one character per cycle while the queue is not full.
// A two-entry queue lets input run on while the result register is stalled.
// Reset (aresetn low, synchronous) clears the parse state and the queue.
// Depends on gllf_pkg, gllf_front, gllf_queue, gllf_back.
module genre_line_field_locator import gllf_pkg::*; #(
    parameter int MAX_LINE = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // char_code [7:0], line_length [20:8]
    input  logic        s_tlast,   // line_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // field_start [11:0], field_length [24:12]
    output logic [3:0]  m_tuser,   // field_kind [2:0], truncated [3]
    output logic        m_tlast    // line_done
);

    localparam int CW = $clog2(MAX_LINE + 1);
    localparam int MW = $bits(rec_meta_t);
    localparam int RW = TOTAL_W + 2 * CW + MW;

    logic               push, q_full, pop, head_valid;
    rec_meta_t          f_meta, b_meta;
    logic [CW-1:0]      f_start, f_want, b_start, b_want;
    logic [TOTAL_W-1:0] f_total, b_total;
    logic [RW-1:0]      wr_data, rd_data;

    gllf_front #(.MAX_LINE(MAX_LINE), .CW(CW)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .char_code   (s_tdata[CHAR_W-1:0]),
        .line_length (s_tdata[CHAR_W+TOTAL_W-1:CHAR_W]),
        .line_last   (s_tlast),
        .q_full      (q_full),
        .push        (push),
        .rec_meta    (f_meta),
        .rec_start   (f_start),
        .rec_want    (f_want),
        .rec_total   (f_total)
    );

    assign wr_data = {f_total, f_want, f_start, f_meta};

    gllf_queue #(.W(RW)) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .wr_data    (wr_data),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .rd_data    (rd_data)
    );

    assign b_meta  = rd_data[MW-1:0];
    assign b_start = rd_data[MW+CW-1:MW];
    assign b_want  = rd_data[MW+2*CW-1:MW+CW];
    assign b_total = rd_data[RW-1:MW+2*CW];

    gllf_back #(.CW(CW)) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .pop        (pop),
        .rec_meta   (b_meta),
        .rec_start  (b_start),
        .rec_want   (b_want),
        .rec_total  (b_total),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
